### rtl/setc_pkg.sv
// Package for the scope edge trigger capture block.
// Holds the sequencer and trigger types, the field widths and the register and
// opcode codes. Used by the channel interfaces and the top level.
package setc_pkg;

    // Field widths fixed by the item formats.
    localparam int SAMPLE_W = 16;
    localparam int PIXEL_W  = 16;
    localparam int COL_BITS = 9;
    localparam int SOFF_W   = 11;
    localparam int HOLD_W   = 4;

    // Holdoff reload after a full screen.
    localparam logic [HOLD_W-1:0] HOLDOFF_RELOAD = 4'd15;

    // Input opcodes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Result kinds.
    localparam logic KIND_COLUMN = 1'b0;
    localparam logic KIND_APPEND = 1'b1;

    // Mode register values.
    localparam logic MODE_FREE    = 1'b0;
    localparam logic MODE_TRIGGER = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_MODE          = 3'd0;
    localparam logic [2:0] REG_PAUSED        = 3'd1;
    localparam logic [2:0] REG_TRIGGER_LEVEL = 3'd2;
    localparam logic [2:0] REG_SAMPLE_OFFSET = 3'd3;
    localparam logic [2:0] REG_GAIN_Q16      = 3'd4;
    localparam logic [2:0] REG_SCREEN_OFFSET = 3'd5;

    // Trigger phase: armed and searching, edge found in this packet, filling.
    typedef enum logic [1:0] {
        PH_ARMED = 2'd0,
        PH_EDGE  = 2'd1,
        PH_FILL  = 2'd2
    } t_phase;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_READ,
        ST_SCALE,
        ST_MUL,
        ST_EMIT
    } t_state;

endpackage

### rtl/setc_in_if.sv
// Input channel of the scope edge trigger capture block: valid/ready plus
// the opcode and raw sample of one item. Depends on setc_pkg.
interface setc_in_if import setc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output opcode, output sample, input ready);
    modport sink   (input valid, input opcode, input sample, output ready);
endinterface

### rtl/setc_out_if.sv
// Result channel of the scope edge trigger capture block: valid/ready plus
// kind, column, pixel value and last flag of one item. Depends on setc_pkg.
interface setc_out_if import setc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                out_kind;
    logic [COL_BITS-1:0] screen_column;
    logic [PIXEL_W-1:0]  pixel_value;
    logic                last;

    modport source (output valid, output out_kind, output screen_column,
                    output pixel_value, output last, input ready);
    modport sink   (input valid, input out_kind, input screen_column,
                    input pixel_value, input last, output ready);
endinterface

### rtl/scope_edge_trigger_capture_top.sv
// Top level of the scope edge trigger capture block.
// Depends on setc_pkg, setc_in_if and setc_out_if.
//
// Usage: i_in carries sample items and idle poll ticks. Samples collect in a
// packet memory of PACKET_SAMPLES entries. The sample that completes a packet
// starts a run: in free mode, unless paused, every sample is scaled and sent
// as an append; in trigger mode the packet is searched for a rising edge
// through the trigger level and samples from the edge on go to increasing
// screen columns, over later packets, until SCREEN_WIDTH columns are written.
// Then the trigger rearms and a holdoff of 15 ticks drops packets. Results
// leave on o_out. A tick or a sample that does not complete a packet
// leaves the block idle. A completing sample runs an edge search over
// up to PACKET_SAMPLES-2 positions (two memory reads, then one compare
// per position), then per result a memory read, subtract, multiply
// and offset add into the output register.
// Configuration is written over the APB port, one register per word.
// Reset clears the packet fill, the trigger state and the holdoff, and loads
// the register reset values. A stalled receiver holds the output register
// and stops the run; the next input item is taken once the run is over, even
// while the final result still waits.
module scope_edge_trigger_capture_top import setc_pkg::*; #(
    parameter int SCREEN_WIDTH   = 512,
    parameter int PACKET_SAMPLES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    setc_in_if.sink     i_in,
    setc_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W   = $clog2(PACKET_SAMPLES);
    localparam int COL_RAW = $clog2(SCREEN_WIDTH + PACKET_SAMPLES);
    localparam int COL_W   = (COL_RAW > COL_BITS) ? COL_RAW : COL_BITS;

    localparam logic [IDX_W-1:0] IDX_LAST      = IDX_W'(PACKET_SAMPLES - 1);
    localparam logic [IDX_W-1:0] IDX_SRCH_LAST = IDX_W'(PACKET_SAMPLES - 3);
    localparam logic [IDX_W-1:0] IDX_TWO       = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_ONE       = IDX_W'(1);
    localparam logic [COL_W-1:0] COL_SW        = COL_W'(SCREEN_WIDTH);
    localparam logic [COL_W-1:0] COL_SW_M1     = COL_W'(SCREEN_WIDTH - 1);

    // Configuration registers.
    logic                r_mode;
    logic                r_paused;
    logic [SAMPLE_W-1:0] r_level;
    logic [SAMPLE_W-1:0] r_soff;
    logic [SAMPLE_W-1:0] r_gain;
    logic [SOFF_W-1:0]   r_screen_off;

    // Control state.
    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [IDX_W-1:0] r_fill, n_fill;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [COL_W-1:0] r_col, n_col;
    logic [HOLD_W-1:0] r_holdoff, n_holdoff;
    logic             r_kind, n_kind;
    logic             r_out_valid, n_out_valid;

    // Datapath registers.
    logic [SAMPLE_W-1:0] r_rd_a, r_rd_b;
    logic [SAMPLE_W-1:0] r_diff, n_diff;
    logic [PIXEL_W-1:0]  r_prod, n_prod;
    logic                r_out_kind, n_out_kind;
    logic [COL_BITS-1:0] r_out_col, n_out_col;
    logic [PIXEL_W-1:0]  r_out_pixel, n_out_pixel;
    logic                r_out_last, n_out_last;

    // Packet memory.
    logic [SAMPLE_W-1:0] r_mem [PACKET_SAMPLES];

    logic                cfg_wr;
    logic [2:0]          cfg_idx;
    logic                in_take;
    logic                pkt_done;
    logic                col_over;
    logic                edge_hit;
    logic                out_free;
    logic                idx_last;
    logic                fill_full;
    logic                is_last;
    logic [IDX_W-1:0]    rd_addr_a;
    logic [IDX_W-1:0]    rd_addr_b;
    logic [31:0]         prod_full;

    // Handshake and status terms.
    assign cfg_wr    = psel && penable && pwrite;
    assign cfg_idx   = paddr[4:2];
    assign pready    = 1'b1;
    assign in_take   = i_in.valid && i_in.ready;
    assign pkt_done  = (r_fill == IDX_LAST);
    assign col_over  = (r_col >= COL_SW);
    assign edge_hit  = (r_rd_a <= r_level) && (r_rd_b >= r_level);
    assign out_free  = !r_out_valid || o_out.ready;
    assign idx_last  = (r_idx == IDX_LAST);
    assign fill_full = (r_kind == KIND_COLUMN) && (r_phase == PH_FILL)
                       && (r_col >= COL_SW_M1);
    assign is_last   = idx_last || fill_full;
    assign rd_addr_a = r_idx;
    assign rd_addr_b = (r_state == ST_SRCH_RD) ? (r_idx + IDX_TWO) : r_idx;
    assign prod_full = 32'(r_diff) * 32'(r_gain);

    // Ports.
    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.out_kind      = r_out_kind;
    assign o_out.screen_column = r_out_col;
    assign o_out.pixel_value   = r_out_pixel;
    assign o_out.last          = r_out_last;

    // Register read-back.
    always_comb begin
        unique case (cfg_idx)
            REG_MODE:          prdata = 32'(r_mode);
            REG_PAUSED:        prdata = 32'(r_paused);
            REG_TRIGGER_LEVEL: prdata = 32'(r_level);
            REG_SAMPLE_OFFSET: prdata = 32'(r_soff);
            REG_GAIN_Q16:      prdata = 32'(r_gain);
            REG_SCREEN_OFFSET: prdata = 32'(r_screen_off);
            default:           prdata = 32'd0;
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take && (i_in.opcode == OP_SAMPLE) && pkt_done) begin
                    if (r_mode == MODE_FREE) begin
                        if (!r_paused) begin
                            n_state = ST_READ;
                        end
                    end else if (r_holdoff == '0) begin
                        if (r_phase == PH_ARMED) begin
                            n_state = ST_SRCH_RD;
                        end else if (!col_over) begin
                            n_state = ST_READ;
                        end
                    end
                end
            end
            ST_SRCH_RD: n_state = ST_SRCH_CMP;
            ST_SRCH_CMP: begin
                priority if (edge_hit) begin
                    n_state = ST_READ;
                end else if (r_idx == IDX_SRCH_LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_SRCH_RD;
                end
            end
            ST_READ:  n_state = ST_SCALE;
            ST_SCALE: n_state = ST_MUL;
            ST_MUL:   n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = is_last ? ST_IDLE : ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and trigger state updates.
    always_comb begin
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_kind      = r_kind;
        n_phase     = r_phase;
        n_col       = r_col;
        n_holdoff   = r_holdoff;
        n_diff      = r_diff;
        n_prod      = r_prod;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_col   = r_out_col;
        n_out_pixel = r_out_pixel;
        n_out_last  = r_out_last;

        // The receiver frees the output register.
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_take && (i_in.opcode == OP_TICK)) begin
                    // Ticks count the holdoff down in trigger mode only.
                    if ((r_mode == MODE_TRIGGER) && (r_holdoff != '0)) begin
                        n_holdoff = r_holdoff - HOLD_W'(1);
                    end
                end else if (in_take) begin
                    n_fill = pkt_done ? '0 : (r_fill + IDX_ONE);
                    n_idx  = '0;
                    n_kind = (r_mode == MODE_FREE) ? KIND_APPEND : KIND_COLUMN;
                    // A full screen found at packet start rearms with no result.
                    if (pkt_done && (r_mode == MODE_TRIGGER) && (r_holdoff == '0)
                        && (r_phase != PH_ARMED) && col_over) begin
                        n_phase   = PH_ARMED;
                        n_col     = '0;
                        n_holdoff = HOLDOFF_RELOAD;
                    end
                end
            end
            ST_SRCH_RD: begin
            end
            ST_SRCH_CMP: begin
                // An edge at position p starts the writes at p-1.
                if (edge_hit) begin
                    n_idx   = r_idx + IDX_ONE;
                    n_phase = PH_EDGE;
                end else if (r_idx != IDX_SRCH_LAST) begin
                    n_idx = r_idx + IDX_ONE;
                end
            end
            ST_READ: begin
            end
            ST_SCALE: begin
                n_diff = (r_rd_a >= r_soff) ? (r_rd_a - r_soff) : '0;
            end
            ST_MUL: begin
                n_prod = prod_full[31:16];
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_kind;
                    n_out_col   = (r_kind == KIND_COLUMN) ? r_col[COL_BITS-1:0] : '0;
                    n_out_pixel = r_prod + {{(PIXEL_W - SOFF_W){r_screen_off[SOFF_W-1]}},
                                            r_screen_off};
                    n_out_last  = is_last;
                    n_idx       = r_idx + IDX_ONE;
                    if (r_kind == KIND_COLUMN) begin
                        n_col = r_col + COL_W'(1);
                        if (is_last) begin
                            // Screen full with samples left: rearm and drop them.
                            if (fill_full && !idx_last) begin
                                n_phase   = PH_ARMED;
                                n_col     = '0;
                                n_holdoff = HOLDOFF_RELOAD;
                            end else if (r_phase == PH_EDGE) begin
                                n_phase = PH_FILL;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_ARMED;
            r_fill       <= '0;
            r_idx        <= '0;
            r_col        <= '0;
            r_holdoff    <= '0;
            r_kind       <= KIND_APPEND;
            r_out_valid  <= 1'b0;
            r_mode       <= MODE_FREE;
            r_paused     <= 1'b0;
            r_level      <= SAMPLE_W'(99);
            r_soff       <= '0;
            r_gain       <= SAMPLE_W'(512);
            r_screen_off <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_fill      <= n_fill;
            r_idx       <= n_idx;
            r_col       <= n_col;
            r_holdoff   <= n_holdoff;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
            if (cfg_wr && pready) begin
                unique case (cfg_idx)
                    REG_MODE:          r_mode       <= pwdata[0];
                    REG_PAUSED:        r_paused     <= pwdata[0];
                    REG_TRIGGER_LEVEL: r_level      <= pwdata[SAMPLE_W-1:0];
                    REG_SAMPLE_OFFSET: r_soff       <= pwdata[SAMPLE_W-1:0];
                    REG_GAIN_Q16:      r_gain       <= pwdata[SAMPLE_W-1:0];
                    REG_SCREEN_OFFSET: r_screen_off <= pwdata[SOFF_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_diff      <= n_diff;
        r_prod      <= n_prod;
        r_out_kind  <= n_out_kind;
        r_out_col   <= n_out_col;
        r_out_pixel <= n_out_pixel;
        r_out_last  <= n_out_last;
    end

    // Packet memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (in_take && (i_in.opcode == OP_SAMPLE)) begin
            r_mem[r_fill] <= i_in.sample;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

endmodule

### dv/tb_top.sv
// Testbench for the scope edge trigger capture block: random packets, ticks and
// register settings, with every result checked against an in-bench predictor.
// Depends on setc_pkg, setc_in_if, setc_out_if and scope_edge_trigger_capture_top.
module tb_top;
    import setc_pkg::*;

    localparam int SCREEN_COLS   = 512;
    localparam int PACKET_LEN    = 32;
    // Settle time covering the worst run: edge search over the packet plus every result.
    localparam int SETTLE_CYCLES = 256;
    localparam int RUN_LIMIT     = 2_000_000;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // Sample patterns for one packet.
    localparam int PKT_NOISE   = 0;
    localparam int PKT_EDGE    = 1;
    localparam int PKT_FALLING = 2;

    typedef struct packed {
        logic                kind;
        logic [COL_BITS-1:0] col;
        logic [PIXEL_W-1:0]  pix;
        logic                last;
    } t_scope_pixel;

    // Predicts the pixels of each packet and checks them in order.
    class t_scope_capture_sb;
        logic                mode;
        logic                paused;
        logic [SAMPLE_W-1:0] level;
        logic [SAMPLE_W-1:0] soff;
        logic [15:0]         gain;
        logic [SOFF_W-1:0]   scr_off;
        logic [SAMPLE_W-1:0] packet[PACKET_LEN];
        int                  fill;
        int                  tpos;
        int                  wcol;
        int                  hold;
        t_phase              phase;
        t_scope_pixel        pixels_due[$];
        t_scope_pixel        run_q[$];
        int                  errors;
        int                  checked;
        int                  items;
        int                  free_runs;
        int                  edges;
        int                  captures;

        function new();
            mode      = MODE_FREE;
            paused    = 1'b0;
            level     = 16'd99;
            soff      = '0;
            gain      = 16'd512;
            scr_off   = '0;
            fill      = 0;
            tpos      = 0;
            wcol      = 0;
            hold      = 0;
            phase     = PH_ARMED;
            errors    = 0;
            checked   = 0;
            items     = 0;
            free_runs = 0;
            edges     = 0;
            captures  = 0;
        endfunction

        // Bits above each register's width are dropped; unknown indexes do nothing.
        function void write_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_MODE:          mode    = v[0];
                REG_PAUSED:        paused  = v[0];
                REG_TRIGGER_LEVEL: level   = v[15:0];
                REG_SAMPLE_OFFSET: soff    = v[15:0];
                REG_GAIN_Q16:      gain    = v[15:0];
                REG_SCREEN_OFFSET: scr_off = v[SOFF_W-1:0];
                default: ;
            endcase
        endfunction

        // Offset removal saturating at zero, Q16 gain, then signed screen offset.
        function logic [PIXEL_W-1:0] scale_pixel(logic [SAMPLE_W-1:0] s);
            logic [SAMPLE_W-1:0] d;
            logic [31:0]         prod;
            d    = (s >= soff) ? s - soff : '0;
            prod = {16'd0, d} * {16'd0, gain};
            return prod[31:16] + {{(PIXEL_W-SOFF_W){scr_off[SOFF_W-1]}}, scr_off};
        endfunction

        function void add_pixel(logic kind, int col, logic [SAMPLE_W-1:0] s);
            t_scope_pixel p;
            p.kind = kind;
            p.col  = col[COL_BITS-1:0];
            p.pix  = scale_pixel(s);
            p.last = 1'b0;
            run_q.push_back(p);
        endfunction

        // Called for every accepted input item.
        function void note_input(logic op, logic [SAMPLE_W-1:0] smp);
            int i;
            items++;
            if (op == OP_TICK) begin
                if (mode == MODE_TRIGGER && hold != 0) hold--;
                return;
            end
            packet[fill] = smp;
            fill++;
            if (fill < PACKET_LEN) return;
            fill = 0;
            run_q.delete();
            if (mode == MODE_FREE) begin
                if (!paused) begin
                    free_runs++;
                    for (i = 0; i < PACKET_LEN; i++) add_pixel(KIND_APPEND, 0, packet[i]);
                end
            end else if (hold == 0) begin
                // Search for the first rising crossing of the level.
                if (phase == PH_ARMED) begin
                    for (i = 2; i < PACKET_LEN; i++) begin
                        if (packet[i-2] <= level && packet[i] >= level) begin
                            tpos  = i - 1;
                            phase = PH_EDGE;
                            break;
                        end
                    end
                end
                if (phase == PH_EDGE) begin
                    edges++;
                    for (i = tpos; i < PACKET_LEN; i++) begin
                        add_pixel(KIND_COLUMN, wcol, packet[i]);
                        wcol++;
                    end
                    phase = PH_FILL;
                end else if (phase == PH_FILL) begin
                    // A full screen rearms and drops the rest of the packet.
                    i = 0;
                    while (phase == PH_FILL && i < PACKET_LEN) begin
                        if (wcol >= SCREEN_COLS) begin
                            hold  = HOLDOFF_RELOAD;
                            wcol  = 0;
                            phase = PH_ARMED;
                            captures++;
                        end else begin
                            add_pixel(KIND_COLUMN, wcol, packet[i]);
                            wcol++;
                            i++;
                        end
                    end
                end
            end
            if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
            foreach (run_q[k]) pixels_due.push_back(run_q[k]);
        endfunction

        // Called for every accepted result item.
        function void check_pixel(t_scope_pixel got);
            t_scope_pixel want;
            if (pixels_due.size() == 0) begin
                $error("result with nothing expected: kind %0d column %0d pixel %h",
                       got.kind, got.col, got.pix);
                errors++;
                return;
            end
            want = pixels_due.pop_front();
            checked++;
            if (got.kind !== want.kind) begin
                $error("out_kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.col !== want.col) begin
                $error("screen_column: expected %0d, got %0d", want.col, got.col);
                errors++;
            end
            if (got.pix !== want.pix) begin
                $error("pixel_value: expected %h, got %h", want.pix, got.pix);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    setc_in_if  in_if ();
    setc_out_if out_if ();

    t_scope_capture_sb sb;
    int                hold_req = 0;
    bit                in_steady = 1'b0;

    scope_edge_trigger_capture_top #(
        .SCREEN_WIDTH   (SCREEN_COLS),
        .PACKET_SAMPLES (PACKET_LEN)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Keeps the register bits and fills the unused upper bits with noise.
    function automatic logic [31:0] pad_noise(logic [31:0] v, int w);
        logic [31:0] keep;
        keep = (32'd1 << w) - 32'd1;
        return (v & keep) | ($urandom & ~keep);
    endfunction

    // One register write: setup cycle, then access cycle.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.write_reg(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one input item, after a random gap unless steady, and waits for it to be taken.
    task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = in_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.opcode <= op;
        in_if.sample <= smp;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_input(op, smp);
    endtask

    // Sends n samples of one pattern with idle ticks mixed in.
    task automatic send_samples(input int style, input int n);
        int                  cut;
        logic [SAMPLE_W-1:0] lvl;
        logic [SAMPLE_W-1:0] cur;
        lvl = sb.level;
        cut = $urandom_range(0, n - 1);
        cur = 16'($urandom_range(32768, 65535));
        if ($urandom_range(0, 3) == 0) in_steady = !in_steady;
        for (int j = 0; j < n; j++) begin
            if ($urandom_range(0, 9) == 0) send_item(OP_TICK, 16'($urandom));
            case (style)
                PKT_EDGE: begin
                    if (j < cut) send_item(OP_SAMPLE, 16'($urandom_range(0, lvl)));
                    else send_item(OP_SAMPLE, 16'($urandom_range(lvl, 65535)));
                end
                PKT_FALLING: begin
                    // Strictly falling samples never cross the level upward.
                    send_item(OP_SAMPLE, cur);
                    cur = cur - 16'($urandom_range(1, 1024));
                end
                default: send_item(OP_SAMPLE, 16'($urandom));
            endcase
        end
    endtask

    // Stops offering items until every expected result is in and the block is idle.
    task automatic quiesce();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pixels_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic shuffle_scaling();
        apb_write(REG_SAMPLE_OFFSET, pad_noise($urandom >> $urandom_range(16, 31), 16));
        apb_write(REG_GAIN_Q16, pad_noise($urandom >> $urandom_range(16, 31), 16));
        apb_write(REG_SCREEN_OFFSET,
                  pad_noise(32'($urandom_range(0, 1024)) - 32'd512, SOFF_W));
    endtask

    // Result side: random stalls, an occasional long hold-off, and checking.
    initial begin
        int           stall;
        bit           steady;
        t_scope_pixel got;
        steady = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 47) == 0) steady = !steady;
            if (hold_req > 0) begin
                stall    = hold_req;
                hold_req = 0;
            end else begin
                stall = steady ? 0 : $urandom_range(0, 15);
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            got.kind = out_if.out_kind;
            got.col  = out_if.screen_column;
            got.pix  = out_if.pixel_value;
            got.last = out_if.last;
            sb.check_pixel(got);
        end
    end

    // Stimulus sequence.
    initial begin
        int guard;
        int seen_captures;
        sb = new();
        in_if.valid  <= 1'b0;
        in_if.opcode <= OP_SAMPLE;
        in_if.sample <= '0;
        out_if.ready <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_rst_n      <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Opening packet with sample extremes and ticks, default settings.
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_SAMPLE, 16'h0000);
        send_item(OP_SAMPLE, 16'hFFFF);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_SAMPLE, 16'h8000);
        send_item(OP_SAMPLE, 16'h7FFF);
        send_item(OP_SAMPLE, 16'hAAAA);
        send_item(OP_SAMPLE, 16'h5555);
        send_samples(PKT_FALLING, PACKET_LEN - 6);
        quiesce();

        // Paused free mode consumes a packet silently.
        apb_write(REG_PAUSED, pad_noise(1, 1));
        send_samples(PKT_NOISE, PACKET_LEN);
        quiesce();

        // Full gain, saturating offset, screen offset of -512.
        apb_write(REG_PAUSED, pad_noise(0, 1));
        apb_write(REG_GAIN_Q16, pad_noise(16'hFFFF, 16));
        apb_write(REG_SAMPLE_OFFSET, pad_noise(16'h8000, 16));
        apb_write(REG_SCREEN_OFFSET, pad_noise(32'h600, SOFF_W));
        apb_write(REG_UNUSED, $urandom);

        // Long receiver hold while packets keep coming, so the input stalls.
        hold_req = 600;
        repeat (2) send_samples(PKT_NOISE, PACKET_LEN);
        quiesce();

        // Zero gain, zero offset, screen offset of +512.
        apb_write(REG_GAIN_Q16, pad_noise(0, 16));
        apb_write(REG_SAMPLE_OFFSET, pad_noise(0, 16));
        apb_write(REG_SCREEN_OFFSET, pad_noise(32'h200, SOFF_W));
        send_samples(PKT_NOISE, PACKET_LEN);
        quiesce();
        repeat (2) begin
            shuffle_scaling();
            send_samples(PKT_NOISE, PACKET_LEN);
            quiesce();
        end

        // Switch to triggered mode with a packet partly filled.
        send_samples(PKT_NOISE, 10);
        quiesce();
        apb_write(REG_MODE, pad_noise(32'(MODE_TRIGGER), 1));
        apb_write(REG_TRIGGER_LEVEL, pad_noise(16'hFFFF, 16));
        send_samples(PKT_NOISE, PACKET_LEN - 10);
        send_samples(PKT_EDGE, PACKET_LEN);

        // Fill a whole screen, sit out the holdoff, and trigger once more.
        guard         = 0;
        seen_captures = 0;
        while (!(sb.captures > 0 && sb.phase == PH_FILL) && guard < 200) begin
            guard++;
            if (sb.captures != seen_captures) begin
                seen_captures = sb.captures;
                quiesce();
                apb_write(REG_TRIGGER_LEVEL, pad_noise(0, 16));
            end
            if (sb.hold != 0) begin
                if ($urandom_range(0, 3) == 0) send_samples(PKT_NOISE, PACKET_LEN);
                else repeat ($urandom_range(1, 6)) send_item(OP_TICK, 16'($urandom));
            end else if (sb.phase == PH_ARMED) begin
                send_samples(($urandom_range(0, 3) == 0) ? PKT_FALLING : PKT_EDGE,
                             PACKET_LEN);
            end else begin
                case ($urandom_range(0, 7))
                    0: begin
                        // A free-mode packet in the middle of a capture.
                        quiesce();
                        apb_write(REG_MODE, pad_noise(32'(MODE_FREE), 1));
                        send_samples(PKT_NOISE, PACKET_LEN);
                        quiesce();
                        apb_write(REG_MODE, pad_noise(32'(MODE_TRIGGER), 1));
                    end
                    1: begin
                        quiesce();
                        shuffle_scaling();
                    end
                    default: send_samples(PKT_NOISE, PACKET_LEN);
                endcase
            end
        end

        quiesce();
        $display("Covered %0d input items: %0d free runs, %0d trigger edges, %0d full screens.",
                 sb.items, sb.free_runs, sb.edges, sb.captures);
        $display("Checked %0d results, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pixels_due.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #RUN_LIMIT;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/setc_pkg.sv
rtl/setc_in_if.sv
rtl/setc_out_if.sv
rtl/scope_edge_trigger_capture_top.sv
dv/tb_top.sv
